>>> rtl/lrsd_pkg.sv
package lrsd_pkg;

  localparam int Rows        = 8;
  localparam int LedsPerWord = 16;

  localparam int RowW      = $clog2(Rows);
  localparam int RowOutW   = 3;
  localparam int PhaseW    = 2;
  localparam int LevelW    = 2;
  localparam int NumLevels = 4;
  localparam int SchedW    = 4;
  localparam int LevelsW   = 32;
  localparam int CntW      = (LedsPerWord > 1) ? $clog2(LedsPerWord) : 1;

  typedef enum logic [1:0] {
    OP_ROW_START  = 2'd0,
    OP_SHIFT_WORD = 2'd1,
    OP_LATCH      = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_ROW_INFO = 2'd0,
    KIND_SERIAL   = 2'd1,
    KIND_LATCH    = 2'd2
  } kind_e;

  // scan position seen by one item
  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [PhaseW-1:0] phase;
  } scan_t;

  typedef logic [NumLevels-1:0][SchedW-1:0] sched_t;

endpackage

>>> rtl/led_row_scan_dimming_serializer_unit.sv
// Row-scanned LED driver with four-phase temporal dimming. A row start transfer
// steps the row counter (and the dimming phase on row wrap) and returns one row
// info result; a latch transfer returns one result with the row select; a shift
// word transfer returns sixteen serial data results, first LED first, each the
// schedule bit of that LED's level at the current phase. Opcode 3 is dropped
// with no result. Every result carries row, mirrored row and phase as seen by
// its own transfer. Results go out at one per cycle while out_ready_i is high;
// row start and latch give one result each, shift word gives sixteen. An input
// transfer is taken while the last result of the previous item goes out, so
// single-result items also stream at one per cycle. Items pass the work
// register, then the result register. Schedule registers are written at any
// time with no wait state, but must only change while the block is idle.
module led_row_scan_dimming_serializer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          opcode_i,
  input  logic [lrsd_pkg::LevelsW-1:0]        levels_i,
  // results
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          kind_o,
  output logic                                serial_bit_o,
  output logic [lrsd_pkg::RowOutW-1:0]        row_index_o,
  output logic [lrsd_pkg::RowOutW-1:0]        mirrored_row_o,
  output logic [lrsd_pkg::PhaseW-1:0]         phase_o,
  output logic                                last_o,
  // schedule register writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [$clog2(lrsd_pkg::NumLevels)-1:0] cfg_index_i,
  input  logic [lrsd_pkg::SchedW-1:0]         cfg_data_i
);

  logic              in_xfer;
  logic              advance;
  logic              load;
  lrsd_pkg::kind_e   load_kind;
  lrsd_pkg::scan_t   scan;
  lrsd_pkg::sched_t  sched_q, sched_d;

  assign in_xfer = in_valid_i && in_ready_o;

  // decode opcode, unused code gets neither a load nor a counter step
  always_comb begin
    advance   = 1'b0;
    load      = 1'b0;
    load_kind = lrsd_pkg::KIND_ROW_INFO;
    unique case (opcode_i)
      lrsd_pkg::OP_ROW_START: begin
        advance   = in_xfer;
        load      = in_xfer;
        load_kind = lrsd_pkg::KIND_ROW_INFO;
      end
      lrsd_pkg::OP_SHIFT_WORD: begin
        load      = in_xfer;
        load_kind = lrsd_pkg::KIND_SERIAL;
      end
      lrsd_pkg::OP_LATCH: begin
        load      = in_xfer;
        load_kind = lrsd_pkg::KIND_LATCH;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // schedule registers, bit p is the on state in phase p
  assign cfg_ready_o = 1'b1;

  always_comb begin
    sched_d = sched_q;
    if (cfg_valid_i) begin
      sched_d[cfg_index_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_q[0] <= lrsd_pkg::SchedW'(4'h0);
      sched_q[1] <= lrsd_pkg::SchedW'(4'h8);
      sched_q[2] <= lrsd_pkg::SchedW'(4'ha);
      sched_q[3] <= lrsd_pkg::SchedW'(4'hf);
    end else begin
      sched_q <= sched_d;
    end
  end

  // row and phase counters, snapshot travels with the item
  lrsd_counters u_counters (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .scan_o    (scan)
  );

  // work register plus result register
  lrsd_serializer u_serializer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .load_kind_i    (load_kind),
    .load_levels_i  (levels_i),
    .load_scan_i    (scan),
    .take_ok_o      (in_ready_o),
    .sched_i        (sched_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .serial_bit_o   (serial_bit_o),
    .row_index_o    (row_index_o),
    .mirrored_row_o (mirrored_row_o),
    .phase_o        (phase_o),
    .last_o         (last_o)
  );

  // single-result kinds always close their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != lrsd_pkg::KIND_SERIAL)) |-> last_o)
    else $error("row info or latch result without last");

  // row and latch results never drive data
  a_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != lrsd_pkg::KIND_SERIAL)) |-> !serial_bit_o)
    else $error("serial bit set on non-data result");

  // phase only moves when the row counter wraps to zero
  a_phase_on_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (scan.phase != $past(scan.phase))) |-> (scan.row == '0))
    else $error("phase stepped without row wrap");

  // mirrored row pairs with row index
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lrsd_pkg::RowOutW'(row_index_o + mirrored_row_o)
                     == lrsd_pkg::RowOutW'(lrsd_pkg::Rows - 1)))
    else $error("mirrored row does not match row index");

endmodule

>>> rtl/lrsd_counters.sv
module lrsd_counters (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  output lrsd_pkg::scan_t     scan_o
);

  lrsd_pkg::scan_t scan_q, scan_d;

  always_comb begin
    scan_d = scan_q;
    if (advance_i) begin
      if (scan_q.row == lrsd_pkg::RowW'(lrsd_pkg::Rows - 1)) begin
        scan_d.row   = '0;
        scan_d.phase = scan_q.phase + 1'b1;
      end else begin
        scan_d.row = scan_q.row + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else begin
      scan_q <= scan_d;
    end
  end

  // row start reports the position after the step
  assign scan_o = scan_d;

endmodule

>>> rtl/lrsd_serializer.sv
module lrsd_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  lrsd_pkg::kind_e               load_kind_i,
  input  logic [lrsd_pkg::LevelsW-1:0]  load_levels_i,
  input  lrsd_pkg::scan_t               load_scan_i,
  output logic                          take_ok_o,
  input  lrsd_pkg::sched_t              sched_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic                          serial_bit_o,
  output logic [lrsd_pkg::RowOutW-1:0]  row_index_o,
  output logic [lrsd_pkg::RowOutW-1:0]  mirrored_row_o,
  output logic [lrsd_pkg::PhaseW-1:0]   phase_o,
  output logic                          last_o
);

  localparam int WordW = lrsd_pkg::LevelW * lrsd_pkg::LedsPerWord;

  // work register
  logic                           w_valid_q, w_valid_d;
  lrsd_pkg::kind_e                w_kind_q, w_kind_d;
  logic [WordW-1:0]               w_levels_q, w_levels_d;
  lrsd_pkg::scan_t                w_scan_q, w_scan_d;
  logic [lrsd_pkg::CntW-1:0]      w_cnt_q, w_cnt_d;

  // result register
  logic                           o_valid_q, o_valid_d;
  lrsd_pkg::kind_e                o_kind_q, o_kind_d;
  logic                           o_bit_q, o_bit_d;
  logic [lrsd_pkg::RowOutW-1:0]   o_row_q, o_row_d;
  logic [lrsd_pkg::RowOutW-1:0]   o_mirror_q, o_mirror_d;
  logic [lrsd_pkg::PhaseW-1:0]    o_phase_q, o_phase_d;
  logic                           o_last_q, o_last_d;

  logic                           w_last;
  logic                           out_load;
  logic [lrsd_pkg::LevelW-1:0]    lvl;
  logic [lrsd_pkg::RowW-1:0]      mirror;

  assign w_last    = (w_kind_q != lrsd_pkg::KIND_SERIAL) || (w_cnt_q == '0);
  assign out_load  = w_valid_q && (!o_valid_q || out_ready_i);
  assign take_ok_o = !w_valid_q || (out_load && w_last);
  assign lvl       = w_levels_q[lrsd_pkg::LevelW-1:0];
  assign mirror    = lrsd_pkg::RowW'(lrsd_pkg::Rows - 1) - w_scan_q.row;

  always_comb begin
    w_valid_d  = w_valid_q;
    w_kind_d   = w_kind_q;
    w_levels_d = w_levels_q;
    w_scan_d   = w_scan_q;
    w_cnt_d    = w_cnt_q;
    if (out_load) begin
      if (w_last) begin
        w_valid_d = 1'b0;
      end else begin
        w_levels_d = w_levels_q >> lrsd_pkg::LevelW;
        w_cnt_d    = w_cnt_q - 1'b1;
      end
    end
    if (load_i) begin
      w_valid_d  = 1'b1;
      w_kind_d   = load_kind_i;
      w_levels_d = load_levels_i[WordW-1:0];
      w_scan_d   = load_scan_i;
      w_cnt_d    = lrsd_pkg::CntW'(lrsd_pkg::LedsPerWord - 1);
    end
  end

  always_comb begin
    o_valid_d  = o_valid_q;
    o_kind_d   = o_kind_q;
    o_bit_d    = o_bit_q;
    o_row_d    = o_row_q;
    o_mirror_d = o_mirror_q;
    o_phase_d  = o_phase_q;
    o_last_d   = o_last_q;
    if (out_load) begin
      o_valid_d  = 1'b1;
      o_kind_d   = w_kind_q;
      o_bit_d    = (w_kind_q == lrsd_pkg::KIND_SERIAL) && sched_i[lvl][w_scan_q.phase];
      o_row_d    = lrsd_pkg::RowOutW'(w_scan_q.row);
      o_mirror_d = lrsd_pkg::RowOutW'(mirror);
      o_phase_d  = w_scan_q.phase;
      o_last_d   = w_last;
    end else if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      w_valid_q <= w_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_kind_q   <= w_kind_d;
    w_levels_q <= w_levels_d;
    w_scan_q   <= w_scan_d;
    w_cnt_q    <= w_cnt_d;
    o_kind_q   <= o_kind_d;
    o_bit_q    <= o_bit_d;
    o_row_q    <= o_row_d;
    o_mirror_q <= o_mirror_d;
    o_phase_q  <= o_phase_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o    = o_valid_q;
  assign kind_o         = o_kind_q;
  assign serial_bit_o   = o_bit_q;
  assign row_index_o    = o_row_q;
  assign mirrored_row_o = o_mirror_q;
  assign phase_o        = o_phase_q;
  assign last_o         = o_last_q;

endmodule
